[rtl/core/dxtbd_pkg.sv]
// Shared types and constants of the DXT1/DXT3 block decoder.
`default_nettype none

package dxtbd_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	localparam int unsigned SIZE_W  = 15;
	localparam int unsigned COORD_W = 14;
	localparam int unsigned BLK_W   = 12;

	typedef enum logic [1:0] {
		CFG_MODE   = 2'd0,
		CFG_WIDTH  = 2'd1,
		CFG_HEIGHT = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic              dxt3;
		logic [SIZE_W-1:0] width;
		logic [SIZE_W-1:0] height;
	} cfg_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	typedef struct packed {
		rgb_t [3:0]       pal;
		logic             pal3_opaque;
		logic             dxt3;
		logic [31:0]      idx;
		logic [63:0]      alpha_word;
		logic [15:0]      mask;
		logic [BLK_W-1:0] col;
		logic [BLK_W-1:0] row;
	} blk_t;

endpackage

`default_nettype wire

[rtl/core/dxt1_dxt3_block_decoder.sv]
// Top level of the DXT1/DXT3 texture block decoder.
// A compressed 4x4 block is offered on color_word, alpha_word, block_col and
// block_row and is taken at a clock edge where start is high and busy is low.
// Configuration registers are written through cfg_valid, cfg_index and
// cfg_data; cfg_ready is always high, and the registers should be changed
// only while no block is in flight.
// Each decoded pixel comes out for one cycle with pixel_strobe high, in raster
// order within the block, and last_pixel marks the final pixel of a block.
// The receiver cannot stall the output, so no backpressure reaches the result side.
// A block passes the front-end stage register, the block queue and the back end's
// current-block register before its pixels reach the output registers. The back
// end walks all sixteen pixel positions of a block, one per cycle; pixels outside
// the image leave empty cycles. A block that lies wholly outside the image
// produces no pixel and is dropped by the front end without entering the queue.
// The front end keeps taking blocks while the back end works, until the
// block queue is full; busy then stays high until the back end frees an entry.
// Reset selects DXT1 with a 1x1 image and empties the pipeline.
`default_nettype none

module dxt1_dxt3_block_decoder #(
	parameter int unsigned QUEUE_DEPTH = dxtbd_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           start,
	output logic                          busy,
	input  wire  [63:0]                   color_word,
	input  wire  [63:0]                   alpha_word,
	input  wire  [dxtbd_pkg::BLK_W-1:0]   block_col,
	input  wire  [dxtbd_pkg::BLK_W-1:0]   block_row,
	input  wire                           cfg_valid,
	output logic                          cfg_ready,
	input  wire  [1:0]                    cfg_index,
	input  wire  [dxtbd_pkg::SIZE_W-1:0]  cfg_data,
	output logic                          pixel_strobe,
	output logic [dxtbd_pkg::COORD_W-1:0] pixel_x,
	output logic [dxtbd_pkg::COORD_W-1:0] pixel_y,
	output logic [7:0]                    red,
	output logic [7:0]                    green,
	output logic [7:0]                    blue,
	output logic [7:0]                    alpha,
	output logic                          last_pixel
);
	import dxtbd_pkg::*;

	cfg_t cfg_q;
	logic q_full;
	logic q_empty;
	logic q_push;
	logic q_pop;
	blk_t push_data;
	blk_t pop_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dxt3   <= 1'b0;
			cfg_q.width  <= SIZE_W'(1);
			cfg_q.height <= SIZE_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MODE: begin
					cfg_q.dxt3 <= cfg_data[0];
				end
				CFG_WIDTH: begin
					cfg_q.width <= cfg_data;
				end
				CFG_HEIGHT: begin
					cfg_q.height <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	dxtbd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.start      (start),
		.busy       (busy),
		.color_word (color_word),
		.alpha_word (alpha_word),
		.block_col  (block_col),
		.block_row  (block_row),
		.q_full     (q_full),
		.push       (q_push),
		.push_data  (push_data)
	);

	dxtbd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (pop_data),
		.empty     (q_empty)
	);

	dxtbd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_data       (pop_data),
		.q_pop        (q_pop),
		.pixel_strobe (pixel_strobe),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.alpha        (alpha),
		.last_pixel   (last_pixel)
	);

endmodule

`default_nettype wire

[rtl/core/dxtbd_front.sv]
// Front end: takes a compressed block, builds its palette and visibility mask.
`default_nettype none

module dxtbd_front (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire  dxtbd_pkg::cfg_t       cfg,
	input  wire                         start,
	output logic                        busy,
	input  wire  [63:0]                 color_word,
	input  wire  [63:0]                 alpha_word,
	input  wire  [dxtbd_pkg::BLK_W-1:0] block_col,
	input  wire  [dxtbd_pkg::BLK_W-1:0] block_row,
	input  wire                         q_full,
	output logic                        push,
	output dxtbd_pkg::blk_t             push_data
);
	import dxtbd_pkg::*;

	function automatic logic [7:0] widen5(input logic [4:0] v);
		return {v, v[4:2]};
	endfunction

	function automatic logic [7:0] widen6(input logic [5:0] v);
		return {v, v[5:4]};
	endfunction

	// Division by three through the reciprocal 683/2048; the 8-bit result is exact for sums below 768.
	function automatic logic [7:0] div3(input logic [9:0] s);
		logic [19:0] p;
		p = s * 10'd683;
		return p[18:11];
	endfunction

	function automatic logic [7:0] mix(input logic [7:0] a, input logic [7:0] b);
		return div3({1'b0, a, 1'b0} + {2'b00, b});
	endfunction

	logic             valid_s1;
	logic [63:0]      cw_s1;
	logic [63:0]      aw_s1;
	logic [BLK_W-1:0] col_s1;
	logic [BLK_W-1:0] row_s1;

	logic             advance;
	logic             accept;
	rgb_t             p0;
	rgb_t             p1;
	rgb_t             p2;
	rgb_t             p3;
	logic [8:0]       sum_r;
	logic [8:0]       sum_g;
	logic [8:0]       sum_b;
	logic             four_color;
	logic [3:0]       col_ok;
	logic [3:0]       row_ok;
	logic [15:0]      mask;

	always_comb begin
		p0.r = widen5(cw_s1[15:11]);
		p0.g = widen6(cw_s1[10:5]);
		p0.b = widen5(cw_s1[4:0]);
		p1.r = widen5(cw_s1[31:27]);
		p1.g = widen6(cw_s1[26:21]);
		p1.b = widen5(cw_s1[20:16]);
		four_color = cfg.dxt3 || (cw_s1[15:0] > cw_s1[31:16]);
		sum_r = {1'b0, p0.r} + {1'b0, p1.r};
		sum_g = {1'b0, p0.g} + {1'b0, p1.g};
		sum_b = {1'b0, p0.b} + {1'b0, p1.b};
		if (four_color) begin
			p2.r = mix(p0.r, p1.r);
			p2.g = mix(p0.g, p1.g);
			p2.b = mix(p0.b, p1.b);
			p3.r = mix(p1.r, p0.r);
			p3.g = mix(p1.g, p0.g);
			p3.b = mix(p1.b, p0.b);
		end else begin
			p2.r = sum_r[8:1];
			p2.g = sum_g[8:1];
			p2.b = sum_b[8:1];
			p3   = '0;
		end
		for (int i = 0; i < 4; i++) begin
			col_ok[i] = {1'b0, col_s1, 2'(i)} < cfg.width;
			row_ok[i] = {1'b0, row_s1, 2'(i)} < cfg.height;
		end
		for (int n = 0; n < 16; n++) begin
			mask[n] = col_ok[n % 4] && row_ok[n / 4];
		end
	end

	assign advance = !valid_s1 || !q_full || (mask == '0);
	assign busy    = !advance;
	assign accept  = start && advance;
	assign push    = valid_s1 && !q_full && (mask != '0);

	always_comb begin
		push_data.pal         = {p3, p2, p1, p0};
		push_data.pal3_opaque = four_color;
		push_data.dxt3        = cfg.dxt3;
		push_data.idx         = cw_s1[63:32];
		push_data.alpha_word  = aw_s1;
		push_data.mask        = mask;
		push_data.col         = col_s1;
		push_data.row         = row_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cw_s1  <= color_word;
			aw_s1  <= alpha_word;
			col_s1 <= block_col;
			row_s1 <= block_row;
		end
	end

endmodule

`default_nettype wire

[rtl/core/dxtbd_queue.sv]
// Short queue of decoded block descriptors between the front and back ends.
`default_nettype none

module dxtbd_queue #(
	parameter int unsigned DEPTH = dxtbd_pkg::QUEUE_DEPTH_DEF
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  wire dxtbd_pkg::blk_t push_data,
	output logic             full,
	input  wire              pop,
	output dxtbd_pkg::blk_t  pop_data,
	output logic             empty
);
	import dxtbd_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	blk_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = count_q == CNT_W'(DEPTH);
	assign empty    = count_q == '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

[rtl/core/dxtbd_back.sv]
// Back end: walks the sixteen pixels of a block and emits the visible ones.
`default_nettype none

module dxtbd_back (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           q_empty,
	input  wire  dxtbd_pkg::blk_t         q_data,
	output logic                          q_pop,
	output logic                          pixel_strobe,
	output logic [dxtbd_pkg::COORD_W-1:0] pixel_x,
	output logic [dxtbd_pkg::COORD_W-1:0] pixel_y,
	output logic [7:0]                    red,
	output logic [7:0]                    green,
	output logic [7:0]                    blue,
	output logic [7:0]                    alpha,
	output logic                          last_pixel
);
	import dxtbd_pkg::*;

	logic        active_q;
	logic [3:0]  n_q;
	blk_t        cur_q;
	logic        strobe_q;

	logic        free;
	logic        emit;
	logic [1:0]  sel;
	logic [3:0]  nib;
	logic [15:0] upper;
	rgb_t        color;
	logic [7:0]  a_val;
	logic        is_last;

	assign free  = !active_q || (n_q == 4'd15);
	assign q_pop = free && !q_empty;

	always_comb begin
		logic [31:0] idx_sh;
		logic [63:0] aw_sh;
		idx_sh  = cur_q.idx >> {n_q, 1'b0};
		aw_sh   = cur_q.alpha_word >> {n_q, 2'b00};
		sel     = idx_sh[1:0];
		nib     = aw_sh[3:0];
		upper   = cur_q.mask >> n_q;
		is_last = upper[15:1] == '0;
		emit    = active_q && upper[0];
		color   = cur_q.pal[sel];
		if (cur_q.dxt3) begin
			a_val = {nib, nib};
		end else if ((sel == 2'd3) && !cur_q.pal3_opaque) begin
			a_val = 8'd0;
		end else begin
			a_val = 8'd255;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			n_q      <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= emit;
			if (free) begin
				active_q <= !q_empty;
				n_q      <= '0;
			end else begin
				n_q <= n_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_data;
		end
		if (emit) begin
			pixel_x    <= {cur_q.col, n_q[1:0]};
			pixel_y    <= {cur_q.row, n_q[3:2]};
			red        <= color.r;
			green      <= color.g;
			blue       <= color.b;
			alpha      <= a_val;
			last_pixel <= is_last;
		end
	end

	assign pixel_strobe = strobe_q;

endmodule

`default_nettype wire

[rtl/core/dxtbd_checker.sv]
// Port-level checker of the block decoder and its bind to the top level.
`default_nettype none

module dxtbd_checker (
	input wire                           clk,
	input wire                           arst_n,
	input wire                           start,
	input wire                           busy,
	input wire                           cfg_valid,
	input wire                           cfg_ready,
	input wire [1:0]                     cfg_index,
	input wire [dxtbd_pkg::SIZE_W-1:0]   cfg_data,
	input wire                           pixel_strobe,
	input wire [dxtbd_pkg::COORD_W-1:0]  pixel_x,
	input wire [dxtbd_pkg::COORD_W-1:0]  pixel_y,
	input wire                           last_pixel
);
	import dxtbd_pkg::*;

	logic [SIZE_W-1:0] width_q;
	logic [SIZE_W-1:0] height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_W'(1);
			height_q <= SIZE_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_WIDTH) begin
				width_q <= cfg_data;
			end
			if (cfg_index == CFG_HEIGHT) begin
				height_q <= cfg_data;
			end
		end
	end

	// Every emitted pixel lies inside the configured image.
	a_inside_image: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_strobe |-> ({1'b0, pixel_x} < width_q) && ({1'b0, pixel_y} < height_q))
		else $error("pixel emitted outside the image");

	// Within a block, pixels advance in raster order.
	a_raster_order: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_strobe && $past(pixel_strobe) && !$past(last_pixel) |->
			(pixel_y > $past(pixel_y)) ||
			((pixel_y == $past(pixel_y)) && (pixel_x > $past(pixel_x))))
		else $error("pixels of a block out of raster order");

	// The block port only becomes busy after a block has been offered.
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(busy) && !$past(start) |-> !busy)
		else $error("busy raised without a block taken");

	// The pixel after the last pixel of a block is never the same pixel again.
	a_last_strobed: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_strobe && last_pixel |=> !pixel_strobe ||
			(pixel_y != $past(pixel_y)) || (pixel_x != $past(pixel_x)))
		else $error("pixel repeated after the last pixel of a block");

endmodule

bind dxt1_dxt3_block_decoder dxtbd_checker u_dxtbd_checker (.*);

`default_nettype wire
